[src/integer_to_text_formatter_defines.svh]
// Assertion macros used by the formatter's sequencer.
`ifndef INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ITF_ASSERT_NOW(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ITF_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

[src/itf_pkg.sv]
// Package with the formatter's constants, flag positions, types and helper functions.
package itf_pkg;

   localparam int MAX_PAD  = 48;
   localparam int MAX_TEXT = 50;
   localparam int NUM_DIGITS = 32;

   localparam int FL_RIGHT  = 0;
   localparam int FL_PLUS   = 1;
   localparam int FL_SPACE  = 2;
   localparam int FL_PREFIX = 3;
   localparam int FL_ZEROS  = 4;
   localparam int FL_UPPER  = 5;
   localparam int FL_SHORT  = 6;

   localparam logic [1:0] BASE_BIN = 2'd0;
   localparam logic [1:0] BASE_OCT = 2'd1;
   localparam logic [1:0] BASE_DEC = 2'd2;
   localparam logic [1:0] BASE_HEX = 2'd3;

   localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 35;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_X_UPPER = 8'h58;
   localparam logic [7:0] CHAR_X_LOWER = 8'h78;
   localparam logic [7:0] CHAR_A_UPPER = 8'h41;
   localparam logic [7:0] CHAR_A_LOWER = 8'h61;

   typedef struct packed {
      logic        start;
      logic [31:0] mag;
      logic [1:0]  sel;
   } div_req_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] quot;
      logic [3:0]  rem;
   } div_rsp_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] char_code;
      logic       last;
   } emit_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] r;
      if (d < 4'd10) begin
         r = CHAR_ZERO + {4'b0, d};
      end else begin
         r = (upper ? CHAR_A_UPPER : CHAR_A_LOWER) + {4'b0, d} - 8'd10;
      end
      return r;
   endfunction

endpackage

[src/itf_div.sv]
// Shared digit unit: splits a magnitude into its lowest digit and the remaining quotient.
module itf_div (
   input  logic                clock,
   input  logic                reset,
   input  itf_pkg::div_req_type div_req,
   output itf_pkg::div_rsp_type div_rsp
);

   logic [63:0] prod;
   logic [28:0] qd_ff, qd_in;
   logic [31:0] mag_ff;
   logic [1:0]  sel_ff;
   logic        valid_ff;
   logic [31:0] qdec;
   logic [31:0] qdec_x10;

   assign prod  = {32'b0, div_req.mag} * {32'b0, itf_pkg::RECIP_TEN};
   assign qd_in = prod[63:itf_pkg::RECIP_SHIFT];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= div_req.start;
      end
      if (div_req.start) begin
         qd_ff  <= qd_in;
         mag_ff <= div_req.mag;
         sel_ff <= div_req.sel;
      end
   end

   assign qdec     = {3'b0, qd_ff};
   assign qdec_x10 = (qdec << 3) + (qdec << 1);

   always_comb begin
      div_rsp.valid = valid_ff;
      unique case (sel_ff)
         itf_pkg::BASE_BIN: begin
            div_rsp.quot = mag_ff >> 1;
            div_rsp.rem  = {3'b0, mag_ff[0]};
         end
         itf_pkg::BASE_OCT: begin
            div_rsp.quot = mag_ff >> 3;
            div_rsp.rem  = {1'b0, mag_ff[2:0]};
         end
         itf_pkg::BASE_DEC: begin
            div_rsp.quot = qdec;
            div_rsp.rem  = mag_ff[3:0] - qdec_x10[3:0];
         end
         default: begin
            div_rsp.quot = mag_ff >> 4;
            div_rsp.rem  = mag_ff[3:0];
         end
      endcase
   end

endmodule

[src/itf_ctrl.sv]
// Sequencer: latches a request, collects digits from the shared unit and emits the text.
`include "integer_to_text_formatter_defines.svh"

module itf_ctrl #(
   parameter int MAX_PAD = itf_pkg::MAX_PAD
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [31:0]          value,
   input  logic [1:0]           base_select,
   input  logic                 is_signed,
   input  logic [5:0]           pad_width,
   input  logic [6:0]           format_flags,
   output logic                 idle,
   output itf_pkg::div_req_type div_req,
   input  itf_pkg::div_rsp_type div_rsp,
   output itf_pkg::emit_type    emit,
   input  logic                 emit_ready
);

   localparam int PAD_LIMIT_INT = (MAX_PAD < itf_pkg::MAX_TEXT) ? MAX_PAD : itf_pkg::MAX_TEXT;
   localparam logic [5:0] PAD_LIMIT = 6'(PAD_LIMIT_INT);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SIZE = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   localparam logic [1:0] LAY_RIGHT      = 2'd0;
   localparam logic [1:0] LAY_FILL_FIRST = 2'd1;
   localparam logic [1:0] LAY_ZERO_MID   = 2'd2;

   localparam logic [1:0] SEG_PRE  = 2'd0;
   localparam logic [1:0] SEG_FILL = 2'd1;
   localparam logic [1:0] SEG_DIG  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [1:0] layout_ff, layout_in;
   logic [1:0] sel_ff, sel_in;
   logic [7:0] fill_char_ff, fill_char_in;
   logic       upper_ff, upper_in;
   logic [5:0] pad_ff, pad_in;
   logic [7:0] pre0_ff, pre0_in;
   logic [7:0] pre1_ff, pre1_in;
   logic [1:0] pre_cnt_ff, pre_cnt_in;
   logic [5:0] fill_cnt_ff, fill_cnt_in;
   logic [5:0] dig_cnt_ff, dig_cnt_in;
   logic [3:0] digit_ff [itf_pkg::NUM_DIGITS];

   logic [31:0] v_masked;
   logic        neg;
   logic [31:0] mag;
   logic [1:0]  sel;
   logic        hex_or_oct;
   logic [5:0]  text_len;
   logic [1:0]  seg;
   logic [5:0]  remaining;
   logic [4:0]  dig_idx;
   logic        take_digit;
   logic        advance;

   assign v_masked   = format_flags[itf_pkg::FL_SHORT] ? {16'b0, value[15:0]} : value;
   assign neg        = is_signed && v_masked[31];
   assign mag        = neg ? (32'd0 - v_masked) : v_masked;
   assign sel        = is_signed ? itf_pkg::BASE_DEC : base_select;
   assign hex_or_oct = (sel == itf_pkg::BASE_OCT) || (sel == itf_pkg::BASE_HEX);

   assign take_digit = (state_ff == ST_CONV) && div_rsp.valid;
   assign idle       = (state_ff == ST_IDLE);
   assign text_len   = {4'b0, pre_cnt_ff} + dig_cnt_ff;
   assign remaining  = {4'b0, pre_cnt_ff} + fill_cnt_ff + dig_cnt_ff;
   assign dig_idx    = 5'(dig_cnt_ff - 6'd1);
   assign advance    = emit.valid && emit_ready;

   always_comb begin
      div_req.start = (idle && accept) || (take_digit && (div_rsp.quot != 32'd0));
      div_req.mag   = idle ? mag : div_rsp.quot;
      div_req.sel   = idle ? sel : sel_ff;
   end

   always_comb begin
      unique case (layout_ff)
         LAY_RIGHT:
            seg = (pre_cnt_ff != 2'd0) ? SEG_PRE : ((dig_cnt_ff != 6'd0) ? SEG_DIG : SEG_FILL);
         LAY_FILL_FIRST:
            seg = (fill_cnt_ff != 6'd0) ? SEG_FILL : ((pre_cnt_ff != 2'd0) ? SEG_PRE : SEG_DIG);
         default:
            seg = (pre_cnt_ff != 2'd0) ? SEG_PRE : ((fill_cnt_ff != 6'd0) ? SEG_FILL : SEG_DIG);
      endcase
   end

   always_comb begin
      emit.valid = (state_ff == ST_EMIT);
      emit.last  = (remaining == 6'd1);
      unique case (seg)
         SEG_PRE:  emit.char_code = pre0_ff;
         SEG_FILL: emit.char_code = fill_char_ff;
         default:  emit.char_code = itf_pkg::digit_char(digit_ff[dig_idx], upper_ff);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      layout_in    = layout_ff;
      sel_in       = sel_ff;
      fill_char_in = fill_char_ff;
      upper_in     = upper_ff;
      pad_in       = pad_ff;
      pre0_in      = pre0_ff;
      pre1_in      = pre1_ff;
      pre_cnt_in   = pre_cnt_ff;
      fill_cnt_in  = fill_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in   = ST_CONV;
               sel_in     = sel;
               upper_in   = format_flags[itf_pkg::FL_UPPER];
               pad_in     = (pad_width > PAD_LIMIT) ? PAD_LIMIT : pad_width;
               dig_cnt_in = 6'd0;
               fill_cnt_in = 6'd0;
               if (format_flags[itf_pkg::FL_RIGHT]) begin
                  layout_in = LAY_RIGHT;
               end else if (is_signed || !format_flags[itf_pkg::FL_ZEROS]) begin
                  layout_in = LAY_FILL_FIRST;
               end else begin
                  layout_in = LAY_ZERO_MID;
               end
               fill_char_in = (!format_flags[itf_pkg::FL_RIGHT] && format_flags[itf_pkg::FL_ZEROS])
                              ? itf_pkg::CHAR_ZERO : itf_pkg::CHAR_SPACE;
               pre1_in    = format_flags[itf_pkg::FL_UPPER] ? itf_pkg::CHAR_X_UPPER
                                                            : itf_pkg::CHAR_X_LOWER;
               pre0_in    = itf_pkg::CHAR_ZERO;
               pre_cnt_in = 2'd0;
               if (is_signed) begin
                  if (neg) begin
                     pre0_in    = itf_pkg::CHAR_MINUS;
                     pre_cnt_in = 2'd1;
                  end else if (format_flags[itf_pkg::FL_PLUS]) begin
                     pre0_in    = itf_pkg::CHAR_PLUS;
                     pre_cnt_in = 2'd1;
                  end else if (format_flags[itf_pkg::FL_SPACE]) begin
                     pre0_in    = itf_pkg::CHAR_SPACE;
                     pre_cnt_in = 2'd1;
                  end
               end else if (format_flags[itf_pkg::FL_PREFIX] && (mag != 32'd0) && hex_or_oct) begin
                  pre_cnt_in = (sel == itf_pkg::BASE_HEX) ? 2'd2 : 2'd1;
               end
            end
         end
         ST_CONV: begin
            if (take_digit) begin
               dig_cnt_in = dig_cnt_ff + 6'd1;
               if (div_rsp.quot == 32'd0) begin
                  state_in = ST_SIZE;
               end
            end
         end
         ST_SIZE: begin
            fill_cnt_in = (pad_ff > text_len) ? (pad_ff - text_len) : 6'd0;
            state_in    = ST_EMIT;
         end
         default: begin
            if (advance) begin
               unique case (seg)
                  SEG_PRE: begin
                     pre_cnt_in = pre_cnt_ff - 2'd1;
                     pre0_in    = pre1_ff;
                  end
                  SEG_FILL: fill_cnt_in = fill_cnt_ff - 6'd1;
                  default:  dig_cnt_in  = dig_cnt_ff - 6'd1;
               endcase
               if (emit.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pre_cnt_ff  <= 2'd0;
         fill_cnt_ff <= 6'd0;
         dig_cnt_ff  <= 6'd0;
      end else begin
         state_ff    <= state_in;
         pre_cnt_ff  <= pre_cnt_in;
         fill_cnt_ff <= fill_cnt_in;
         dig_cnt_ff  <= dig_cnt_in;
      end
      layout_ff    <= layout_in;
      sel_ff       <= sel_in;
      fill_char_ff <= fill_char_in;
      upper_ff     <= upper_in;
      pad_ff       <= pad_in;
      pre0_ff      <= pre0_in;
      pre1_ff      <= pre1_in;
      if (take_digit) begin
         digit_ff[dig_cnt_ff[4:0]] <= div_rsp.rem;
      end
   end

   `ITF_ASSERT_NOW(a_div_only_in_conv, div_rsp.valid, state_ff == ST_CONV,
      "Digit unit returned a result outside conversion.")
   `ITF_ASSERT_NOW(a_emit_has_chars, state_ff == ST_EMIT, remaining != 6'd0,
      "Emitting with no characters left.")
   `ITF_ASSERT_NEXT(a_last_ends_item, advance && emit.last, state_ff == ST_IDLE,
      "Sequencer did not return to idle after the last transfer.")
   `ITF_ASSERT_NOW(a_digit_bound, 1'b1, dig_cnt_ff <= 6'(itf_pkg::NUM_DIGITS),
      "Digit count exceeds the digit buffer.")

endmodule

[src/integer_to_text_formatter.sv]
// Top level of the integer to text formatter with its result output register.
//
// Usage: the request channel (req_valid, req_stall and the req_ fields) takes
// one 32-bit value with its base, signed flag, pad width and format flags.
// The block then drives req_stall high until all characters of that value
// have been handed to the output register, so it works on one value at a time.
// The result channel (rsp_valid, rsp_stall, rsp_out_char, rsp_last_char)
// carries one ASCII character per transfer; rsp_last_char marks the final one.
// Conversion: the shared digit unit returns the digits lowest first (1 to 32 digits),
// a sizing state then works out the fill, and the first character follows.
// Characters then leave one per cycle while the receiver does not stall.
// An item has n characters (n at most 48); the block takes no new value
// until its last character has been handed to the output register.
// When the receiver stalls, the current character holds in the output
// register and the sequencer waits. A new request is taken while the last
// character still waits in the output register.
// Reset is synchronous and active high; it empties the output register and
// returns the sequencer to idle.
module integer_to_text_formatter #(
   parameter int MAX_PAD = itf_pkg::MAX_PAD
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value,
   input  logic [1:0]  req_base_select,
   input  logic        req_is_signed,
   input  logic [5:0]  req_pad_width,
   input  logic [6:0]  req_format_flags,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_char
);

   itf_pkg::div_req_type div_req;
   itf_pkg::div_rsp_type div_rsp;
   itf_pkg::emit_type    emit;

   logic       idle;
   logic       accept;
   logic       emit_ready;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_char_ff;
   logic       rsp_last_ff;

   assign req_stall    = !idle;
   assign accept       = req_valid && idle;
   assign emit_ready   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = emit.valid || (rsp_valid_ff && rsp_stall);

   itf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   itf_ctrl #(
      .MAX_PAD (MAX_PAD)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .value        (req_value),
      .base_select  (req_base_select),
      .is_signed    (req_is_signed),
      .pad_width    (req_pad_width),
      .format_flags (req_format_flags),
      .idle         (idle),
      .div_req      (div_req),
      .div_rsp      (div_rsp),
      .emit         (emit),
      .emit_ready   (emit_ready)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (emit.valid && emit_ready) begin
         rsp_char_ff <= emit.char_code;
         rsp_last_ff <= emit.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

[bench/tb.sv]
// Self-checking testbench for integer_to_text_formatter with directed and random values.
`timescale 1ns / 1ps

module tb;

   typedef struct {
      logic [31:0] value;
      logic [1:0]  base_sel;
      logic        is_signed;
      logic [5:0]  pad;
      logic [6:0]  flags;
      string       text;
   } fmt_row_type;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } text_char_type;

   localparam logic [6:0] F_RIGHT  = 7'(1 << itf_pkg::FL_RIGHT);
   localparam logic [6:0] F_PLUS   = 7'(1 << itf_pkg::FL_PLUS);
   localparam logic [6:0] F_SPACE  = 7'(1 << itf_pkg::FL_SPACE);
   localparam logic [6:0] F_PREFIX = 7'(1 << itf_pkg::FL_PREFIX);
   localparam logic [6:0] F_ZEROS  = 7'(1 << itf_pkg::FL_ZEROS);
   localparam logic [6:0] F_UPPER  = 7'(1 << itf_pkg::FL_UPPER);
   localparam logic [6:0] F_SHORT  = 7'(1 << itf_pkg::FL_SHORT);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_value = '0;
   logic [1:0]  req_base_select = '0;
   logic        req_is_signed = 1'b0;
   logic [5:0]  req_pad_width = '0;
   logic [6:0]  req_format_flags = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_char;
   logic        rsp_last_char;

   text_char_type char_expect_q[$];
   text_char_type head_char;
   fmt_row_type   dir_rows[$];
   int            errors = 0;
   int            chars_taken = 0;
   int            send_idle_pct = 27;
   int            recv_idle_pct = 56;
   bit            long_hold_done = 1'b0;

   integer_to_text_formatter dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_value(req_value),
      .req_base_select(req_base_select),
      .req_is_signed(req_is_signed),
      .req_pad_width(req_pad_width),
      .req_format_flags(req_format_flags),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_char(rsp_out_char),
      .rsp_last_char(rsp_last_char)
   );

   always #5 clock = ~clock;

   function automatic void put_row(input logic [31:0] value, input logic [1:0] base_sel,
                                   input logic is_signed, input logic [5:0] pad,
                                   input logic [6:0] flags, input string text);
      fmt_row_type r;
      r.value = value;
      r.base_sel = base_sel;
      r.is_signed = is_signed;
      r.pad = pad;
      r.flags = flags;
      r.text = text;
      dir_rows.push_back(r);
   endfunction

   function automatic void push_literal(input string s);
      for (int i = 0; i < s.len(); i++) begin
         char_expect_q.push_back('{s[i], i == s.len() - 1});
      end
   endfunction

   function automatic void format_value(input fmt_row_type r);
      logic [31:0] v;
      logic [31:0] mag;
      logic [31:0] radix;
      logic [31:0] d;
      logic [7:0]  lead [2];
      logic [7:0]  digs [32];
      logic [7:0]  text [$];
      logic [7:0]  pad_char;
      int          nlead;
      int          ndig;
      int          width;
      int          fill;
      logic        upper;
      nlead = 0;
      ndig = 0;
      upper = r.flags[itf_pkg::FL_UPPER];
      v = r.value;
      if (r.flags[itf_pkg::FL_SHORT]) begin
         v = v & 32'h0000_FFFF;
      end
      width = int'(r.pad);
      if (width > itf_pkg::MAX_PAD) begin
         width = itf_pkg::MAX_PAD;
      end
      if (width > itf_pkg::MAX_TEXT) begin
         width = itf_pkg::MAX_TEXT;
      end
      if (r.is_signed) begin
         radix = 10;
         mag = v[31] ? -v : v;
         if (v[31]) begin
            lead[0] = itf_pkg::CHAR_MINUS;
            nlead = 1;
         end else if (r.flags[itf_pkg::FL_PLUS]) begin
            lead[0] = itf_pkg::CHAR_PLUS;
            nlead = 1;
         end else if (r.flags[itf_pkg::FL_SPACE]) begin
            lead[0] = itf_pkg::CHAR_SPACE;
            nlead = 1;
         end
      end else begin
         case (r.base_sel)
            itf_pkg::BASE_BIN: radix = 2;
            itf_pkg::BASE_OCT: radix = 8;
            itf_pkg::BASE_DEC: radix = 10;
            default:           radix = 16;
         endcase
         mag = v;
         if (r.flags[itf_pkg::FL_PREFIX] && mag != 0 && (radix == 8 || radix == 16)) begin
            lead[0] = itf_pkg::CHAR_ZERO;
            nlead = 1;
            if (radix == 16) begin
               lead[1] = upper ? itf_pkg::CHAR_X_UPPER : itf_pkg::CHAR_X_LOWER;
               nlead = 2;
            end
         end
      end
      do begin
         d = mag % radix;
         if (d < 10) begin
            digs[ndig] = itf_pkg::CHAR_ZERO + d[7:0];
         end else begin
            digs[ndig] = (upper ? itf_pkg::CHAR_A_UPPER : itf_pkg::CHAR_A_LOWER)
                         + d[7:0] - 8'd10;
         end
         ndig++;
         mag = mag / radix;
      end while (mag != 0 && ndig < 32);
      fill = (width > nlead + ndig) ? width - (nlead + ndig) : 0;
      if (r.flags[itf_pkg::FL_RIGHT]) begin
         for (int i = 0; i < nlead; i++) text.push_back(lead[i]);
         for (int i = ndig - 1; i >= 0; i--) text.push_back(digs[i]);
         for (int i = 0; i < fill; i++) text.push_back(itf_pkg::CHAR_SPACE);
      end else if (r.is_signed || !r.flags[itf_pkg::FL_ZEROS]) begin
         pad_char = r.flags[itf_pkg::FL_ZEROS] ? itf_pkg::CHAR_ZERO : itf_pkg::CHAR_SPACE;
         for (int i = 0; i < fill; i++) text.push_back(pad_char);
         for (int i = 0; i < nlead; i++) text.push_back(lead[i]);
         for (int i = ndig - 1; i >= 0; i--) text.push_back(digs[i]);
      end else begin
         for (int i = 0; i < nlead; i++) text.push_back(lead[i]);
         for (int i = 0; i < fill; i++) text.push_back(itf_pkg::CHAR_ZERO);
         for (int i = ndig - 1; i >= 0; i--) text.push_back(digs[i]);
      end
      foreach (text[i]) begin
         char_expect_q.push_back('{text[i], i == text.size() - 1});
      end
   endfunction

   function automatic fmt_row_type random_value();
      fmt_row_type r;
      case ($urandom_range(5))
         0: r.value = $urandom_range(99);
         1: r.value = -$urandom_range(1000, 1);
         2: begin
            case ($urandom_range(5))
               0: r.value = 32'h0000_0000;
               1: r.value = 32'hFFFF_FFFF;
               2: r.value = 32'h8000_0000;
               3: r.value = 32'h7FFF_FFFF;
               4: r.value = 32'h0000_FFFF;
               default: r.value = 32'h0000_8000;
            endcase
         end
         default: r.value = $urandom;
      endcase
      r.base_sel = 2'($urandom_range(3));
      r.is_signed = 1'($urandom_range(1));
      r.pad = ($urandom_range(3) == 0) ? 6'($urandom_range(48)) : 6'($urandom_range(12));
      r.flags = 7'($urandom_range(127));
      r.text = "";
      return r;
   endfunction

   task automatic offer_value(input fmt_row_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= r.value;
      req_base_select <= r.base_sel;
      req_is_signed <= r.is_signed;
      req_pad_width <= r.pad;
      req_format_flags <= r.flags;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (r.text.len() != 0) begin
         push_literal(r.text);
      end else begin
         format_value(r);
      end
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         chars_taken++;
         if (char_expect_q.size() == 0) begin
            $display("%0t: unexpected character: expected none, actual %h last %b",
                     $time, rsp_out_char, rsp_last_char);
            errors++;
         end else begin
            head_char = char_expect_q.pop_front();
            if (rsp_out_char !== head_char.code) begin
               $display("%0t: out_char mismatch: expected %h, actual %h",
                        $time, head_char.code, rsp_out_char);
               errors++;
            end
            if (rsp_last_char !== head_char.last) begin
               $display("%0t: last_char mismatch: expected %b, actual %b",
                        $time, head_char.last, rsp_last_char);
               errors++;
            end
         end
      end
   end

   // The receiver holds off once for a long stretch so that the block backs up.
   initial begin
      forever begin
         @(negedge clock);
         if (!long_hold_done && chars_taken >= 200) begin
            long_hold_done = 1'b1;
            repeat (150) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("** integer_to_text_formatter: FAILED **");
      $finish;
   end

   initial begin
      put_row(32'h0000_0000, itf_pkg::BASE_DEC, 1'b0, 6'd0, 7'd0, "0");
      put_row(32'hFFFF_FFFF, itf_pkg::BASE_DEC, 1'b0, 6'd0, 7'd0, "4294967295");
      put_row(32'h8000_0000, itf_pkg::BASE_DEC, 1'b1, 6'd0, 7'd0, "-2147483648");
      put_row(32'hFFFF_FFFF, itf_pkg::BASE_HEX, 1'b0, 6'd0, F_PREFIX, "0xffffffff");
      put_row(32'hFFFF_FFFF, itf_pkg::BASE_HEX, 1'b0, 6'd0, F_PREFIX | F_UPPER,
              "0XFFFFFFFF");
      put_row(32'hFFFF_FFFF, itf_pkg::BASE_BIN, 1'b0, 6'd0, 7'd0,
              {"11111111", "11111111", "11111111", "11111111"});
      put_row(32'hFFFF_FFFF, itf_pkg::BASE_OCT, 1'b0, 6'd0, F_PREFIX, "037777777777");
      put_row(32'h0000_0000, itf_pkg::BASE_HEX, 1'b0, 6'd0, F_PREFIX, "0");
      put_row(32'h0000_0000, itf_pkg::BASE_OCT, 1'b0, 6'd0, F_PREFIX, "0");
      put_row(32'hFFFF_FFFB, itf_pkg::BASE_DEC, 1'b1, 6'd5, F_ZEROS, "000-5");
      put_row(32'h0000_0005, itf_pkg::BASE_DEC, 1'b1, 6'd0, F_PLUS, "+5");
      put_row(32'h0000_0005, itf_pkg::BASE_DEC, 1'b1, 6'd0, F_SPACE, " 5");
      put_row(32'h0000_0005, itf_pkg::BASE_DEC, 1'b1, 6'd0, F_PLUS | F_SPACE, "+5");
      put_row(32'h0000_0000, itf_pkg::BASE_DEC, 1'b1, 6'd0, 7'd0, "0");
      put_row(32'h0000_002A, itf_pkg::BASE_DEC, 1'b0, 6'd6, 7'd0, "    42");
      put_row(32'h0000_002A, itf_pkg::BASE_DEC, 1'b0, 6'd6, F_RIGHT | F_ZEROS, "42    ");
      put_row(32'h0000_001F, itf_pkg::BASE_HEX, 1'b0, 6'd6, F_PREFIX | F_ZEROS, "0x001f");
      put_row(32'h0000_001F, itf_pkg::BASE_HEX, 1'b1, 6'd0, F_PREFIX, "31");
      put_row(32'hFFFF_8000, itf_pkg::BASE_DEC, 1'b1, 6'd0, F_SHORT, "32768");
      put_row(32'h1234_ABCD, itf_pkg::BASE_HEX, 1'b0, 6'd0, F_SHORT | F_UPPER, "ABCD");
      put_row(32'h0000_3039, itf_pkg::BASE_DEC, 1'b0, 6'd3, 7'd0, "12345");
      put_row(32'h0000_0009, itf_pkg::BASE_OCT, 1'b0, 6'd4, F_PREFIX | F_ZEROS, "0011");
      put_row(32'h0000_0007, itf_pkg::BASE_DEC, 1'b0, 6'd63, 7'd0, "");
      put_row(32'h0001_E240, itf_pkg::BASE_DEC, 1'b1, 6'd48, F_RIGHT | F_PLUS, "");
      put_row(32'hDEAD_BEEF, itf_pkg::BASE_HEX, 1'b0, 6'd15,
              F_RIGHT | F_PREFIX | F_UPPER | F_ZEROS, "");

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) offer_value(dir_rows[i]);
      repeat (35) offer_value(random_value());
      send_idle_pct = 56;
      recv_idle_pct = 27;
      repeat (35) offer_value(random_value());
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (35) offer_value(random_value());
      req_valid <= 1'b0;

      while (char_expect_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (errors == 0) begin
         $display("** integer_to_text_formatter: PASSED **");
      end else begin
         $display("** integer_to_text_formatter: FAILED **");
      end
      $finish;
   end

endmodule
